[design/rtlu_pkg.sv]
package rtlu_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_BITS     = 48;

  // Fixed field widths
  localparam int TAG_W     = 16;
  localparam int IN_ADDR_W = 64;
  localparam int SIZE_W    = 48;
  localparam int SEG_W     = 48;
  localparam int END_W     = 49;
  localparam int STAT_W    = 3;
  localparam int CNT_OUT_W = 7;

  // Derived widths
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int SUM_W = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [TAG_W-1:0]     tag_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FREE   = 2'd1,
    OP_REMAP  = 2'd2,
    OP_FETCH  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOID     = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_RANGE    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    tag_t  tag;
    addr_t start;
    size_t size;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_EVAL,
    S_FCHK,
    S_SHIFT,
    S_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic ins_write;
    logic scan_en;
    logic eval;
    logic fchk;
    logic shift_en;
    logic publish;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic hit;
    logic scan_end;
    logic mismatch;
    logic shift_done;
    logic out_free;
  } dp_sts_t;

endpackage

[design/rtlu_in_if.sv]
interface rtlu_in_if import rtlu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [TAG_W-1:0]     req_tag;
  logic [IN_ADDR_W-1:0] address;
  logic [IN_ADDR_W-1:0] new_address;
  logic [SIZE_W-1:0]    range_size;
  logic [SIZE_W-1:0]    new_size;

  modport source (output valid, op, req_tag, address, new_address, range_size, new_size,
                  input ready);
  modport sink   (input valid, op, req_tag, address, new_address, range_size, new_size,
                  output ready);
endinterface

[design/rtlu_out_if.sv]
interface rtlu_out_if import rtlu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic                 hit_valid;
  logic [TAG_W-1:0]     hit_tag;
  logic [SEG_W-1:0]     seg_base;
  logic [END_W-1:0]     seg_end;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [CNT_OUT_W-1:0] peak_count;

  modport source (output valid, status, hit_valid, hit_tag, seg_base, seg_end, entry_count,
                  peak_count, input ready);
  modport sink   (input valid, status, hit_valid, hit_tag, seg_base, seg_end, entry_count,
                  peak_count, output ready);
endinterface

[design/rtlu_ram.sv]
module rtlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/rtlu_ctrl.sv]
module rtlu_ctrl import rtlu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  dp_sts_t    sts,
  output ctl_cmd_t   cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (op_t'(in_op) == OP_INSERT) ? S_INSERT : S_SCAN;
        end
      end
      S_INSERT: state_nxt = S_DONE;
      S_SCAN: begin
        priority if (sts.hit)      state_nxt = S_EVAL;
        else if     (sts.scan_end) state_nxt = S_DONE;
        else                       state_nxt = S_SCAN;
      end
      S_EVAL: begin
        priority if (sts.op == OP_FETCH)                  state_nxt = S_FCHK;
        else if     (sts.op == OP_FREE && !sts.mismatch)  state_nxt = S_SHIFT;
        else                                              state_nxt = S_DONE;
      end
      S_FCHK:  state_nxt = S_DONE;
      S_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_INSERT: cmd.ins_write = 1'b1;
      S_SCAN:   cmd.scan_en   = 1'b1;
      S_EVAL:   cmd.eval      = 1'b1;
      S_FCHK:   cmd.fchk      = 1'b1;
      S_SHIFT:  cmd.shift_en  = 1'b1;
      S_DONE:   cmd.publish   = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[design/rtlu_dpath.sv]
module rtlu_dpath import rtlu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_cmd_t             cmd,
  output dp_sts_t              sts,
  // request payload
  input  logic [1:0]           in_op,
  input  logic [TAG_W-1:0]     in_req_tag,
  input  logic [IN_ADDR_W-1:0] in_address,
  input  logic [IN_ADDR_W-1:0] in_new_address,
  input  logic [SIZE_W-1:0]    in_range_size,
  input  logic [SIZE_W-1:0]    in_new_size,
  // result side
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [STAT_W-1:0]    out_status,
  output logic                 out_hit_valid,
  output logic [TAG_W-1:0]     out_hit_tag,
  output logic [SEG_W-1:0]     out_seg_base,
  output logic [END_W-1:0]     out_seg_end,
  output logic [CNT_OUT_W-1:0] out_entry_count,
  output logic [CNT_OUT_W-1:0] out_peak_count
);

  // latched request
  op_t   op_r;
  tag_t  tag_r;
  addr_t addr_r, naddr_r;
  size_t size_r, nsize_r;

  // table bookkeeping
  cnt_t  count_r, peak_r;
  cnt_t  ptr_r;
  logic  rd_vld_r;
  idx_t  rd_idx_r;
  idx_t  pos_r;

  // working result
  status_t          st_r;
  logic             hv_r;
  logic [SEG_W-1:0] seg_base_r;
  logic [END_W-1:0] seg_end_r;
  logic             lt_r;
  addr_t            diff_r;

  // output register
  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic                 out_hit_valid_r;
  logic [TAG_W-1:0]     out_hit_tag_r;
  logic [SEG_W-1:0]     out_seg_base_r;
  logic [END_W-1:0]     out_seg_end_r;
  logic [CNT_OUT_W-1:0] out_entry_count_r;
  logic [CNT_OUT_W-1:0] out_peak_count_r;

  // RAM port
  logic   ram_we, ram_re;
  idx_t   ram_waddr;
  entry_t ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic full, hit, scan_end, mismatch, shift_done, more, out_free, out_of_range;
  logic [SUM_W-1:0] seg_sum;

  rtlu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r[IDX_W-1:0]),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  assign full       = (count_r == CNT_W'(TABLE_ENTRIES));
  assign more       = (ptr_r < count_r);
  assign hit        = rd_vld_r && (ram_rdata.tag == tag_r);
  assign scan_end   = (ptr_r == count_r);
  assign mismatch   = (ram_rdata.start != addr_r) || (ram_rdata.size != size_r);
  assign shift_done = !more && !rd_vld_r;
  assign out_free   = !out_valid_r || out_ready;
  assign seg_sum    = SUM_W'(ram_rdata.start) + SUM_W'(ram_rdata.size);
  assign out_of_range = lt_r || (SUM_W'(diff_r) >= SUM_W'(ram_rdata.size));

  assign sts.op         = op_r;
  assign sts.hit        = hit;
  assign sts.scan_end   = scan_end;
  assign sts.mismatch   = mismatch;
  assign sts.shift_done = shift_done;
  assign sts.out_free   = out_free;

  // read stream: scan stops on a hit so the matching entry stays in the read register
  assign ram_re = (cmd.scan_en && !hit && more) || (cmd.shift_en && more);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[IDX_W-1:0];
    ram_wdata = '{tag: tag_r, start: addr_r, size: size_r};
    priority if (cmd.ins_write && !full) begin
      ram_we = 1'b1;
    end else if (cmd.eval && op_r == OP_REMAP && !mismatch) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r;
      ram_wdata = '{tag: ram_rdata.tag, start: naddr_r, size: nsize_r};
    end else if (cmd.shift_en && rd_vld_r) begin
      // move entry down by one
      ram_we    = 1'b1;
      ram_waddr = rd_idx_r - idx_t'(1);
      ram_wdata = ram_rdata;
    end else begin
      ram_we = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      peak_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= ram_re;
      if (cmd.ins_write && !full) begin
        count_r <= count_r + cnt_t'(1);
        if ((count_r + cnt_t'(1)) > peak_r) begin
          peak_r <= count_r + cnt_t'(1);
        end
      end else if (cmd.shift_en && shift_done) begin
        count_r <= count_r - cnt_t'(1);
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= op_t'(in_op);
      tag_r       <= in_req_tag;
      addr_r      <= in_address[ADDR_BITS-1:0];
      naddr_r     <= in_new_address[ADDR_BITS-1:0];
      size_r      <= in_range_size;
      nsize_r     <= in_new_size;
      ptr_r       <= '0;
      st_r        <= ST_OK;
      hv_r        <= 1'b0;
      seg_base_r  <= '0;
      seg_end_r   <= '0;
    end
    if (ram_re) begin
      ptr_r    <= ptr_r + cnt_t'(1);
      rd_idx_r <= ptr_r[IDX_W-1:0];
    end
    if (cmd.ins_write && full) begin
      st_r <= ST_FULL;
    end
    if (cmd.scan_en) begin
      if (hit) begin
        pos_r <= rd_idx_r;
      end else if (scan_end) begin
        st_r <= ST_NOID;
      end
    end
    if (cmd.eval) begin
      ptr_r <= cnt_t'(pos_r) + cnt_t'(1);
      if ((op_r == OP_FREE || op_r == OP_REMAP) && mismatch) begin
        st_r <= ST_MISMATCH;
      end
      if (op_r == OP_FETCH) begin
        lt_r        <= (addr_r < ram_rdata.start);
        diff_r      <= addr_r - ram_rdata.start;
        seg_base_r  <= SEG_W'(ram_rdata.start);
        seg_end_r   <= END_W'(seg_sum);
      end
    end
    if (cmd.fchk) begin
      if (out_of_range) begin
        st_r        <= ST_RANGE;
        seg_base_r  <= '0;
        seg_end_r   <= '0;
      end else begin
        hv_r <= 1'b1;
      end
    end
    if (cmd.publish) begin
      out_status_r      <= st_r;
      out_hit_valid_r   <= hv_r;
      out_hit_tag_r     <= hv_r ? tag_r : '0;
      out_seg_base_r    <= seg_base_r;
      out_seg_end_r     <= seg_end_r;
      out_entry_count_r <= CNT_OUT_W'(count_r);
      out_peak_count_r  <= CNT_OUT_W'(peak_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hit_valid   = out_hit_valid_r;
  assign out_hit_tag     = out_hit_tag_r;
  assign out_seg_base    = out_seg_base_r;
  assign out_seg_end     = out_seg_end_r;
  assign out_entry_count = out_entry_count_r;
  assign out_peak_count  = out_peak_count_r;

endmodule

[design/range_table_lookup_top.sv]
// Request flow: an insert writes the table at once; every other op scans the table
// from entry 0 until the tag matches or the live count is reached, and a fetch then
// range-checks the matching entry. A free that does not remove the last entry then
// moves later entries down one a cycle. One request in flight; the next can be taken
// from the cycle after the result enters the output register.
// Synchronous active-low reset clears count, peak, FSM and output valid, not the table.
module range_table_lookup_top import rtlu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  rtlu_in_if.sink    in_ch,
  rtlu_out_if.source out_ch
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     in_ready;

  // Controller: sequences insert, linear scan (one entry per cycle through the
  // table RAM's read port), entry check, fetch range check and the
  // down-shift that closes the gap left by a free.
  rtlu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath: request latch, entry RAM, counters and output register.
  // Addresses are cut to ADDR_BITS when latched.
  rtlu_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_ch.op),
    .in_req_tag      (in_ch.req_tag),
    .in_address      (in_ch.address),
    .in_new_address  (in_ch.new_address),
    .in_range_size   (in_ch.range_size),
    .in_new_size     (in_ch.new_size),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_hit_valid   (out_ch.hit_valid),
    .out_hit_tag     (out_ch.hit_tag),
    .out_seg_base    (out_ch.seg_base),
    .out_seg_end     (out_ch.seg_end),
    .out_entry_count (out_ch.entry_count),
    .out_peak_count  (out_ch.peak_count)
  );

endmodule

[design/rtlu_checker.sv]
module rtlu_checker import rtlu_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STAT_W-1:0]    out_status,
  input logic                 out_hit_valid,
  input logic [TAG_W-1:0]     out_hit_tag,
  input logic [SEG_W-1:0]     out_seg_base,
  input logic [END_W-1:0]     out_seg_end,
  input logic [CNT_OUT_W-1:0] out_entry_count,
  input logic [CNT_OUT_W-1:0] out_peak_count
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_entry_count) && $stable(out_seg_end))
    else $error("result changed while stalled");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == CNT_OUT_W'(TABLE_ENTRIES))
    else $error("full status with table not full");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_peak_count >= out_entry_count)
    else $error("peak below live count");

  a_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit_valid |->
      out_hit_tag == '0 && out_seg_base == '0 && out_seg_end == '0)
    else $error("segment fields set without hit");

  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit_valid |-> out_status == ST_OK)
    else $error("hit with error status");

endmodule

bind range_table_lookup_top rtlu_checker u_rtlu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_hit_valid   (out_ch.hit_valid),
  .out_hit_tag     (out_ch.hit_tag),
  .out_seg_base    (out_ch.seg_base),
  .out_seg_end     (out_ch.seg_end),
  .out_entry_count (out_ch.entry_count),
  .out_peak_count  (out_ch.peak_count)
);
